### src/assert_macros.svh
// assertion macros for the rtl of the barcode whitelist
// no dependencies; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define BWC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("barcode whitelist assertion failed");
// condition must never be seen out of reset
`define BWC_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("barcode whitelist forbidden condition seen");
`else
`define BWC_ASSERT(lbl, prop)
`define BWC_NEVER(lbl, cond)
`endif
`endif

### src/bwc_pkg.sv
// constants and codes for the barcode whitelist with count and correction
// no dependencies
package bwc_pkg;

    localparam int ENTRIES_DEF    = 1024;
    localparam int COUNT_BITS_DEF = 32;

    localparam int OP_W     = 3;
    localparam int CODE_W   = 64;
    localparam int AMOUNT_W = 32;
    localparam int STATUS_W = 3;
    localparam int EIDX_W   = 10;
    localparam int CTR_W    = 32;
    localparam int LEN_W    = 6;
    localparam int POS_N    = 32;
    localparam int KEY_W    = 7;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 176;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd16;

    // register addresses (word select)
    localparam logic REG_BARCODE_LENGTH = 1'b0;

    // operations
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_HIT     = 3'd2;
    localparam logic [OP_W-1:0] OP_CORRECT = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_AMBIGUOUS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CORRECTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    localparam logic [CTR_W-1:0] CTR_MAX = '1;

endpackage

### src/barcode_whitelist_count_correct.sv
// Barcode whitelist with saturating per-entry counts and single-base correction.
// Every word but a clear runs one pass over the stored entries through the code
// and count memories (one entry per cycle on their shared read port). A new word
// is not accepted until the result of the last one is in the output register.
// The pass checks exact match and one-base neighbours together, so a correction
// costs the same as a lookup. Clearing counts sweeps fill entries, one a cycle,
// fill being the number of entries inserted so far. No clearing pass is needed
// after reset. The result sits in an output register.
// Depends on bwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module barcode_whitelist_count_correct
    import bwc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input word
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // op[2:0], code[66:3], amount[98:67], zero pad
    input  logic                  s_tuser,   // ambiguous
    // result word
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // status[2:0], entry_index[12:3],
                                             // matched_code[76:13], total_seen[108:77],
                                             // ambiguous_seen[140:109],
                                             // matched_seen[172:141], zero pad
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int SUM_W = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_CLR  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic                  amb_reg, amb_next;
    logic [AMOUNT_W-1:0]   amount_reg, amount_next;
    logic [FILL_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic [KEY_W-1:0]      best_key_reg, best_key_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [CODE_W-1:0]     best_code_reg, best_code_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [CTR_W-1:0]      total_reg, total_next;
    logic [CTR_W-1:0]      ambc_reg, ambc_next;
    logic [CTR_W-1:0]      match_reg, match_next;
    logic [LEN_W-1:0]      len_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // memories and their ports
    logic [CODE_W-1:0]     code_mem [ENTRIES];
    logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
    logic [CODE_W-1:0]     rd_code_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  code_we;
    logic                  cnt_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] cnt_wdata;

    // compare path
    logic [POS_N-1:0]      pnz;
    logic [CODE_W-1:0]     diff;
    logic [32:0]           allow_ext;
    logic [4:0]            pos;
    logic [CODE_W-1:0]     shifted;
    logic [KEY_W-1:0]      key;
    logic                  neighbour;
    logic                  better;

    // result path
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS-1:0] sat_cnt;
    logic [STATUS_W-1:0]   status;
    logic [IDX_W-1:0]      res_idx;
    logic [IDX_W+EIDX_W-1:0] res_idx_ext;
    logic [CODE_W-1:0]     res_code;
    logic                  cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BARCODE_LENGTH);
    assign prdata = (paddr[2] == REG_BARCODE_LENGTH) ? {26'd0, len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_wr)
        begin
            len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // code memory
    always_ff @(posedge clk)
    begin
        if (code_we)
        begin
            code_mem[wr_addr] <= code_reg;
        end
        if (rd_en)
        begin
            rd_code_reg <= code_mem[rd_addr];
        end
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[wr_addr] <= cnt_wdata;
        end
        if (rd_en)
        begin
            rd_cnt_reg <= cnt_mem[rd_addr];
        end
    end

    // neighbour test on the entry just read
    always_comb
    begin
        diff = rd_code_reg ^ code_reg;
        pos = 5'd0;
        for (int p = 0; p < POS_N; p++)
        begin
            pnz[p] = |diff[2*p +: 2];
        end
        for (int p = 0; p < POS_N; p++)
        begin
            if (pnz[p])
            begin
                pos = 5'(p);
            end
        end
        allow_ext = (33'd1 << len_reg) - 33'd1;
        shifted = rd_code_reg >> {pos, 1'b0};
        key = {pos, shifted[1:0]};
        neighbour = (pnz != '0) && ((pnz & (pnz - 1'b1)) == '0)
                    && ((pnz & ~allow_ext[31:0]) == '0);
        better = neighbour && (rd_cnt_reg != '0)
                 && ((rd_cnt_reg > best_cnt_reg)
                     || ((rd_cnt_reg == best_cnt_reg) && (key < best_key_reg)));
    end

    // saturating count update
    always_comb
    begin
        sum = ((op_reg == OP_INSERT) ? '0 : SUM_W'(hit_cnt_reg))
              + ((op_reg == OP_HIT) ? SUM_W'(1) : SUM_W'(amount_reg));
        sat_cnt = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_BITS-1:0];
    end

    // control and result
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        code_next = code_reg;
        amb_next = amb_reg;
        amount_next = amount_reg;
        rd_idx_next = rd_idx_reg;
        pend_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        hit_cnt_next = hit_cnt_reg;
        best_cnt_next = best_cnt_reg;
        best_key_next = best_key_reg;
        best_idx_next = best_idx_reg;
        best_code_next = best_code_reg;
        fill_next = fill_reg;
        total_next = total_reg;
        ambc_next = ambc_reg;
        match_next = match_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        rd_en = 1'b0;
        rd_addr = rd_idx_reg[IDX_W-1:0];
        code_we = 1'b0;
        cnt_we = 1'b0;
        wr_addr = rd_idx_reg[IDX_W-1:0];
        cnt_wdata = '0;
        status = ST_MISS;
        res_idx = '0;
        res_code = code_reg;
        res_idx_ext = '0;

        // fold in the entry read last cycle
        if (pend_reg)
        begin
            if ((rd_code_reg == code_reg) && !hit_reg)
            begin
                hit_next = 1'b1;
                hit_idx_next = pend_idx_reg;
                hit_cnt_next = rd_cnt_reg;
            end
            if (better)
            begin
                best_cnt_next = rd_cnt_reg;
                best_key_next = key;
                best_idx_next = pend_idx_reg;
                best_code_next = rd_code_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next = s_tdata[2:0];
                    code_next = s_tdata[66:3];
                    amount_next = s_tdata[98:67];
                    amb_next = s_tuser;
                    rd_idx_next = '0;
                    hit_next = 1'b0;
                    best_cnt_next = '0;
                    state_next = (s_tdata[2:0] == OP_CLEAR) ? S_CLR : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_idx_reg < fill_reg)
                begin
                    rd_en = 1'b1;
                    pend_next = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_CLR:
            begin
                if (rd_idx_reg < fill_reg)
                begin
                    cnt_we = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (amb_reg)
                            begin
                                status = ST_AMBIGUOUS;
                            end
                            else if (hit_reg)
                            begin
                                status = ST_DUPLICATE;
                                res_idx = hit_idx_reg;
                            end
                            else if (fill_reg == FILL_W'(ENTRIES))
                            begin
                                status = ST_FULL;
                            end
                            else
                            begin
                                status = ST_OK;
                                res_idx = fill_reg[IDX_W-1:0];
                                wr_addr = fill_reg[IDX_W-1:0];
                                code_we = 1'b1;
                                cnt_we = 1'b1;
                                cnt_wdata = sat_cnt;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_ADD:
                        begin
                            if (amb_reg)
                            begin
                                status = ST_AMBIGUOUS;
                            end
                            else if (hit_reg)
                            begin
                                status = ST_OK;
                                res_idx = hit_idx_reg;
                                wr_addr = hit_idx_reg;
                                cnt_we = 1'b1;
                                cnt_wdata = sat_cnt;
                            end
                        end
                        OP_HIT:
                        begin
                            total_next = (total_reg == CTR_MAX) ? total_reg
                                                                : total_reg + 1'b1;
                            if (amb_reg)
                            begin
                                status = ST_AMBIGUOUS;
                                ambc_next = (ambc_reg == CTR_MAX) ? ambc_reg
                                                                  : ambc_reg + 1'b1;
                            end
                            else if (hit_reg)
                            begin
                                status = ST_OK;
                                res_idx = hit_idx_reg;
                                wr_addr = hit_idx_reg;
                                cnt_we = 1'b1;
                                cnt_wdata = sat_cnt;
                                match_next = (match_reg == CTR_MAX) ? match_reg
                                                                    : match_reg + 1'b1;
                            end
                        end
                        OP_CORRECT:
                        begin
                            if (amb_reg)
                            begin
                                status = ST_AMBIGUOUS;
                            end
                            else if (hit_reg)
                            begin
                                status = ST_OK;
                                res_idx = hit_idx_reg;
                            end
                            else if (best_cnt_reg != '0)
                            begin
                                status = ST_CORRECTED;
                                res_idx = best_idx_reg;
                                res_code = best_code_reg;
                            end
                        end
                        OP_CLEAR:
                        begin
                            status = ST_OK;
                        end
                        default:
                        begin
                            status = ST_MISS;
                        end
                    endcase
                    res_idx_ext = (IDX_W + EIDX_W)'(res_idx);
                    out_valid_next = 1'b1;
                    out_data_next = {3'd0, match_next, ambc_next, total_next,
                                     res_code, res_idx_ext[EIDX_W-1:0], status};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg <= 1'b0;
            fill_reg <= '0;
            total_reg <= '0;
            ambc_reg <= '0;
            match_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            fill_reg <= fill_next;
            total_reg <= total_next;
            ambc_reg <= ambc_next;
            match_reg <= match_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        code_reg <= code_next;
        amb_reg <= amb_next;
        amount_reg <= amount_next;
        rd_idx_reg <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        hit_reg <= hit_next;
        hit_idx_reg <= hit_idx_next;
        hit_cnt_reg <= hit_cnt_next;
        best_cnt_reg <= best_cnt_next;
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        best_code_reg <= best_code_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // checks
    `BWC_NEVER(a_fill_over, fill_reg > FILL_W'(ENTRIES))
    `BWC_ASSERT(a_fill_step, fill_reg != $past(fill_reg) |-> fill_reg == $past(fill_reg) + 1'b1)
    `BWC_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready)

endmodule
